>>> hdl/kfrs_pkg.sv
package kfrs_pkg;

    localparam int unsigned TIME_BITS     = 48;
    localparam int unsigned LID_BITS      = 8;
    localparam int unsigned ATT_BITS      = 4;
    localparam int unsigned PERIOD_BITS   = 16;
    localparam int unsigned BACKOFF_BITS  = 20;
    localparam int unsigned ACT_BITS      = 2;
    localparam int unsigned CFG_ADDR_BITS = 4;
    localparam int unsigned APB_DATA_BITS = 32;
    localparam int unsigned REG_IDX_BITS  = 2;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam logic [ATT_BITS-1:0]     MAX_ATT_RESET = 4'd3;
    localparam logic [PERIOD_BITS-1:0]  PERIOD_RESET  = 16'd100;
    localparam logic [BACKOFF_BITS-1:0] BACKOFF_RESET = 20'd2000;

    localparam logic [REG_IDX_BITS-1:0] REG_MAX_ATT = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PERIOD  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_BACKOFF = 2'd2;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_STREAM   = 2'd0,
        ACT_KEYFRAME = 2'd1,
        ACT_DAMAGE   = 2'd2,
        ACT_EMPTY    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD
    } t_state;

    typedef struct packed {
        logic [ATT_BITS-1:0]     max_att;
        logic [PERIOD_BITS-1:0]  period;
        logic [BACKOFF_BITS-1:0] backoff;
    } t_cfg;

    typedef struct packed {
        logic [LID_BITS-1:0]  lid;
        logic [ATT_BITS-1:0]  att;
        logic [TIME_BITS-1:0] next_due;
        logic [TIME_BITS-1:0] rearm;
        logic                 done;
        logic                 answered;
    } t_entry;

    function automatic logic [TIME_BITS-1:0] add_sat(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

endpackage

>>> hdl/kfrs_intf.sv
interface kfrs_in_if #(parameter int unsigned KEY_BITS = 32);
    logic                               valid;
    logic                               ready;
    logic [kfrs_pkg::ACT_BITS-1:0]      action;
    logic [kfrs_pkg::TIME_BITS-1:0]     now_ms;
    logic [KEY_BITS-1:0]                stream_key;
    logic [kfrs_pkg::LID_BITS-1:0]      local_id;
    logic                               last_in_round;

    modport source (output valid, action, now_ms, stream_key, local_id, last_in_round,
                    input ready);
    modport sink   (input valid, action, now_ms, stream_key, local_id, last_in_round,
                    output ready);
endinterface

interface kfrs_out_if #(parameter int unsigned KEY_BITS = 32);
    logic                               valid;
    logic                               ready;
    logic [KEY_BITS-1:0]                out_key;
    logic                               request_due;
    logic [kfrs_pkg::ATT_BITS-1:0]      attempt_count;
    logic                               is_settled;
    logic                               table_full;
    logic                               round_end;

    modport source (output valid, out_key, request_due, attempt_count, is_settled,
                    table_full, round_end, input ready);
    modport sink   (input valid, out_key, request_due, attempt_count, is_settled,
                    table_full, round_end, output ready);
endinterface

>>> hdl/keyframe_request_retry_scheduler.sv
// keyframe request retry scheduler
// input channel i_req carries one item per transfer: a latched stream of the
// current round (one result), a keyframe sighting, a damage report or an empty
// round (no result). results leave on o_res, one per latched stream item.
// registers max_attempts, retry_period_ms and rearm_backoff_ms sit on the apb
// port at byte addresses 0, 4 and 8; write them only while the block is idle.
// the stream table lives in one ram read one entry per cycle in a sweep over
// all MAX_STREAMS entries; i_req is not ready until the sweep (and, for a
// latched stream item, the update step that registers its result on o_res)
// is done. an empty round is taken in idle and leaves the block ready.
// damage and keyframe items read, modify and write entries in one sweep; the
// entry written is never the one being read in the same cycle.
// reset restores the register defaults and empties the table at once through
// per-entry valid flags; no clearing pass is needed.
// when the receiver stalls, the result stays in the output register and the
// block still takes the next item, holding a new result until o_res drains.
module keyframe_request_retry_scheduler #(
    parameter int unsigned MAX_STREAMS = 16,
    parameter int unsigned KEY_BITS    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    kfrs_in_if.sink                             i_req,
    kfrs_out_if.source                          o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kfrs_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [kfrs_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [kfrs_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import kfrs_pkg::*;

    localparam int unsigned IW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int unsigned CW = $clog2(MAX_STREAMS + 1);
    localparam int unsigned EW = $bits(t_entry);
    localparam int unsigned RW = KEY_BITS + EW;
    localparam logic [CW-1:0] LAST_CNT = CW'(MAX_STREAMS);

    t_cfg w_cfg;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_p_vld, n_p_vld;
    logic [IW-1:0] r_p_idx, n_p_idx;
    logic r_hit, n_hit;
    logic r_free, n_free;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [IW-1:0] r_free_idx, n_free_idx;
    t_entry r_ent, n_ent;
    logic [MAX_STREAMS-1:0] r_valid, n_valid;
    logic [MAX_STREAMS-1:0] r_seen, n_seen;

    t_action r_act;
    logic [TIME_BITS-1:0] r_now;
    logic [KEY_BITS-1:0] r_key;
    logic [LID_BITS-1:0] r_lid;
    logic r_last;

    logic r_out_vld, n_out_vld;
    logic [KEY_BITS-1:0] r_out_key, n_out_key;
    logic r_out_due, n_out_due;
    logic [ATT_BITS-1:0] r_out_cnt, n_out_cnt;
    logic r_out_settled, n_out_settled;
    logic r_out_full, n_out_full;
    logic r_out_end, n_out_end;

    logic w_in_acc;
    logic w_ram_we, w_ram_re;
    logic [IW-1:0] w_ram_waddr, w_ram_raddr;
    logic [RW-1:0] w_ram_wdata, w_ram_rdata;
    logic [KEY_BITS-1:0] w_rd_key;
    t_entry w_rd_ent, w_mod_ent;
    logic w_rd_spent;

    logic w_use;
    logic [IW-1:0] w_idx;
    t_entry w_base, w_upd;
    logic w_due;
    logic [ATT_BITS-1:0] w_att_inc;
    logic w_settled;

    kfrs_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kfrs_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_STREAMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;

    assign o_res.valid         = r_out_vld;
    assign o_res.out_key       = r_out_key;
    assign o_res.request_due   = r_out_due;
    assign o_res.attempt_count = r_out_cnt;
    assign o_res.is_settled    = r_out_settled;
    assign o_res.table_full    = r_out_full;
    assign o_res.round_end     = r_out_end;

    assign w_rd_key   = w_ram_rdata[RW-1 -: KEY_BITS];
    assign w_rd_ent   = t_entry'(w_ram_rdata[EW-1:0]);
    assign w_rd_spent = (w_rd_ent.att >= w_cfg.max_att);

    // entry update for a latched stream
    always_comb begin
        w_use = r_hit || r_free;
        w_idx = r_hit ? r_hit_idx : r_free_idx;
        if (r_hit) begin
            w_base = r_ent;
        end else begin
            w_base.lid      = r_lid;
            w_base.att      = '0;
            w_base.next_due = r_now;
            w_base.rearm    = '0;
            w_base.done     = 1'b0;
            w_base.answered = 1'b0;
        end
        w_due = w_use && !w_base.done && (w_base.att < w_cfg.max_att)
                && (r_now >= w_base.next_due);
        w_att_inc = w_base.att + ATT_BITS'(1);
        w_upd     = w_base;
        w_upd.lid = r_lid;
        if (w_due) begin
            w_upd.att      = w_att_inc;
            w_upd.next_due = add_sat(r_now, TIME_BITS'(w_cfg.period));
            if (w_att_inc >= w_cfg.max_att) begin
                w_upd.rearm = add_sat(r_now, TIME_BITS'(w_cfg.backoff));
            end
        end
        w_settled = w_use && (w_upd.done || (w_upd.att >= w_cfg.max_att));
    end

    // event modification of the entry read back in the sweep
    always_comb begin
        w_mod_ent = w_rd_ent;
        if (r_act == ACT_KEYFRAME) begin
            w_mod_ent.done     = 1'b1;
            w_mod_ent.answered = 1'b1;
        end else begin
            w_mod_ent.att      = '0;
            w_mod_ent.done     = 1'b0;
            w_mod_ent.next_due = r_now;
            w_mod_ent.answered = 1'b0;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_p_vld       = 1'b0;
        n_p_idx       = r_p_idx;
        n_hit         = r_hit;
        n_free        = r_free;
        n_hit_idx     = r_hit_idx;
        n_free_idx    = r_free_idx;
        n_ent         = r_ent;
        n_valid       = r_valid;
        n_seen        = r_seen;
        n_out_vld     = r_out_vld && !o_res.ready;
        n_out_key     = r_out_key;
        n_out_due     = r_out_due;
        n_out_cnt     = r_out_cnt;
        n_out_settled = r_out_settled;
        n_out_full    = r_out_full;
        n_out_end     = r_out_end;
        w_ram_we      = 1'b0;
        w_ram_waddr   = r_p_idx;
        w_ram_wdata   = {w_rd_key, w_mod_ent};
        w_ram_re      = 1'b0;
        w_ram_raddr   = r_cnt[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cnt  = '0;
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    if (t_action'(i_req.action) == ACT_EMPTY) begin
                        n_valid = '0;
                        n_seen  = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt != LAST_CNT) begin
                    w_ram_re = 1'b1;
                    n_p_vld  = 1'b1;
                    n_p_idx  = r_cnt[IW-1:0];
                    n_cnt    = r_cnt + CW'(1);
                end
                if (r_p_vld) begin
                    case (r_act)
                        ACT_STREAM: begin
                            if (r_valid[r_p_idx] && (w_rd_key == r_key) && !r_hit) begin
                                n_hit     = 1'b1;
                                n_hit_idx = r_p_idx;
                                n_ent     = w_rd_ent;
                            end
                            if (!r_valid[r_p_idx] && !r_free) begin
                                n_free     = 1'b1;
                                n_free_idx = r_p_idx;
                            end
                        end
                        ACT_KEYFRAME: begin
                            w_ram_we = r_valid[r_p_idx] && (w_rd_ent.lid == r_lid);
                        end
                        ACT_DAMAGE: begin
                            w_ram_we = r_valid[r_p_idx] && (w_rd_ent.lid == r_lid)
                                       && (w_rd_ent.done || w_rd_spent)
                                       && (w_rd_ent.answered || (r_now >= w_rd_ent.rearm));
                        end
                        default: ;
                    endcase
                end
                if (r_cnt == LAST_CNT) begin
                    n_state = (r_act == ACT_STREAM) ? S_UPD : S_IDLE;
                end
            end
            S_UPD: begin
                if (!r_out_vld || o_res.ready) begin
                    w_ram_we      = w_use;
                    w_ram_waddr   = w_idx;
                    w_ram_wdata   = {r_key, w_upd};
                    n_out_vld     = 1'b1;
                    n_out_key     = r_key;
                    n_out_due     = w_due;
                    n_out_cnt     = w_use ? w_upd.att : '0;
                    n_out_settled = w_settled;
                    n_out_full    = !w_use;
                    n_out_end     = r_last;
                    if (w_use) begin
                        n_valid[w_idx] = 1'b1;
                        n_seen[w_idx]  = 1'b1;
                    end
                    if (r_last) begin
                        n_valid = n_valid & n_seen;
                        n_seen  = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_p_vld   <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_valid   <= '0;
            r_seen    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_p_vld   <= n_p_vld;
            r_hit     <= n_hit;
            r_free    <= n_free;
            r_valid   <= n_valid;
            r_seen    <= n_seen;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act  <= t_action'(i_req.action);
            r_now  <= i_req.now_ms;
            r_key  <= i_req.stream_key;
            r_lid  <= i_req.local_id;
            r_last <= i_req.last_in_round;
        end
        r_p_idx       <= n_p_idx;
        r_hit_idx     <= n_hit_idx;
        r_free_idx    <= n_free_idx;
        r_ent         <= n_ent;
        r_out_key     <= n_out_key;
        r_out_due     <= n_out_due;
        r_out_cnt     <= n_out_cnt;
        r_out_settled <= n_out_settled;
        r_out_full    <= n_out_full;
        r_out_end     <= n_out_end;
    end

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.table_full |->
            !o_res.request_due && (o_res.attempt_count == '0) && !o_res.is_settled)
        else $error("table full result carries attempt state");

    a_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && w_ram_we |-> (r_act != ACT_STREAM))
        else $error("stream lookup wrote the table during its sweep");

    a_prune_clears_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) && (n_state == S_IDLE) && r_last |=> (r_seen == '0))
        else $error("seen flags survive the end of a round");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> ($past(r_state) == S_UPD))
        else $error("result raised outside the update step");

endmodule

>>> hdl/kfrs_ram.sv
module kfrs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/kfrs_apb.sv
module kfrs_apb (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kfrs_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [kfrs_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [kfrs_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output kfrs_pkg::t_cfg                      o_cfg
);
    import kfrs_pkg::*;

    t_cfg                    r_cfg;
    logic [REG_IDX_BITS-1:0] w_idx;
    logic                    w_wr;

    assign w_idx  = paddr[CFG_ADDR_BITS-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_att <= MAX_ATT_RESET;
            r_cfg.period  <= PERIOD_RESET;
            r_cfg.backoff <= BACKOFF_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_MAX_ATT: r_cfg.max_att <= pwdata[ATT_BITS-1:0];
                REG_PERIOD:  r_cfg.period  <= pwdata[PERIOD_BITS-1:0];
                REG_BACKOFF: r_cfg.backoff <= pwdata[BACKOFF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAX_ATT: prdata = APB_DATA_BITS'(r_cfg.max_att);
            REG_PERIOD:  prdata = APB_DATA_BITS'(r_cfg.period);
            REG_BACKOFF: prdata = APB_DATA_BITS'(r_cfg.backoff);
            default:     prdata = '0;
        endcase
    end
endmodule
